### design/fenwick_rank_counter_core_defines.svh
// assertion macros shared by the checker
`ifndef FENWICK_RANK_COUNTER_CORE_DEFINES_SVH
`define FENWICK_RANK_COUNTER_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define FRC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define FRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### design/frc_pkg.sv
package frc_pkg;

  localparam int KEY_BITS   = 10;
  localparam int COUNT_BITS = 20;
  localparam int RANK_BITS  = 21;
  localparam int POS_BITS   = KEY_BITS + 2;
  localparam int TREE_SIZE  = 1 << KEY_BITS;
  localparam int CMP_BITS   = (COUNT_BITS + 1 > RANK_BITS) ? COUNT_BITS + 1 : RANK_BITS;

  typedef logic [KEY_BITS-1:0]   addr_t;
  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [POS_BITS-1:0]   pos_t;
  typedef logic [RANK_BITS-1:0]  rank_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PREFIX,
    ST_INSERT
  } state_t;

  // sequencer to walker
  typedef struct packed {
    logic  clear;
    addr_t clr_addr;
    logic  load;
    logic  prefix;
    logic  insert;
  } ctrl_t;

  // walker to sequencer
  typedef struct packed {
    logic done;
  } stat_t;

  // lowest set bit of a tree position
  function automatic pos_t low_bit(input pos_t pos);
    low_bit = pos & (~pos + pos_t'(1));
  endfunction

  // node exists in the tree (1 .. TREE_SIZE)
  function automatic logic in_range(input pos_t pos);
    in_range = (pos != '0) && (pos <= pos_t'(TREE_SIZE));
  endfunction

endpackage

### design/fenwick_rank_counter_core.sv
// insert only (func 0): busy from the accept beat until the update walk ends
// rank then insert (func 1): busy through prefix and update walks, rank strobed
// in the cycle after the prefix walk ends; one tree node per cycle over one read port
// items: one at a time, the next start is taken once busy is low
// reset: synchronous rst, then a clearing pass over all 2^KEY_BITS entries, busy high
// results cannot be stalled: rank_valid marks rank for exactly one cycle
module fenwick_rank_counter_core
  import frc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic                 func,
  input  logic [KEY_BITS-1:0]  key,
  output logic [RANK_BITS-1:0] rank,
  output logic                 rank_valid
);

  // sequencer <-> walker
  ctrl_t  ctrl;
  stat_t  stat;

  // tree memory port
  logic   mem_we;
  addr_t  mem_waddr;
  count_t mem_wdata;
  logic   mem_re;
  addr_t  mem_raddr;
  count_t mem_rdata;

  // clear pass, then idle, prefix walk (func 1 only), update walk
  frc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .func  (func),
    .stat  (stat),
    .ctrl  (ctrl),
    .busy  (busy)
  );

  // node walker: issues one read per cycle, handles the previous read's data
  // (accumulate in prefix, saturating write-back in update)
  frc_walk u_walk (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .key        (key),
    .stat       (stat),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata),
    .rank       (rank),
    .rank_valid (rank_valid)
  );

  // tree counts, node p at entry p-1, registered read
  frc_tree_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

### design/frc_tree_mem.sv
module frc_tree_mem
  import frc_pkg::*;
(
  input  logic   clk,
  input  logic   we,
  input  addr_t  waddr,
  input  count_t wdata,
  input  logic   re,
  input  addr_t  raddr,
  output count_t rdata
);

  count_t mem [TREE_SIZE];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/frc_ctrl.sv
module frc_ctrl
  import frc_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  logic  func,
  input  stat_t stat,
  output ctrl_t ctrl,
  output logic  busy
);

  state_t state, state_next;
  addr_t  clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + addr_t'(1);
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_addr == '1) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) state_next = func ? ST_PREFIX : ST_INSERT;
      end
      ST_PREFIX: begin
        if (stat.done) state_next = ST_INSERT;
      end
      ST_INSERT: begin
        if (stat.done) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl          = '0;
    ctrl.clr_addr = clr_addr;
    busy          = 1'b1;
    unique case (state)
      ST_CLEAR:  ctrl.clear = 1'b1;
      ST_IDLE: begin
        busy      = 1'b0;
        ctrl.load = start;
      end
      ST_PREFIX: ctrl.prefix = 1'b1;
      ST_INSERT: ctrl.insert = 1'b1;
      default:   busy = 1'b1;
    endcase
  end

endmodule

### design/frc_walk.sv
module frc_walk
  import frc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  ctrl_t               ctrl,
  input  logic [KEY_BITS-1:0] key,
  output stat_t               stat,
  output logic                mem_we,
  output addr_t               mem_waddr,
  output count_t              mem_wdata,
  output logic                mem_re,
  output addr_t               mem_raddr,
  input  count_t              mem_rdata,
  output rank_t               rank,
  output logic                rank_valid
);

  pos_t   pos, start_pos, key_pos, pos_dec, pos_step, lsb;
  logic   pend;
  addr_t  wr_addr;
  count_t sum, sum_sat, inc;
  logic [COUNT_BITS:0]   sum_wide;
  logic [CMP_BITS-1:0]   rank_wide;
  rank_t  rank_sat;
  logic   active;

  always_comb begin
    active   = ctrl.prefix | ctrl.insert;
    key_pos  = pos_t'(key) + pos_t'(1);
    lsb      = low_bit(pos);
    pos_step = ctrl.prefix ? (pos - lsb) : (pos + lsb);
    pos_dec  = pos - pos_t'(1);

    mem_re    = active & in_range(pos);
    mem_raddr = pos_dec[KEY_BITS-1:0];

    // saturating accumulate and increment
    sum_wide = {1'b0, sum} + {1'b0, mem_rdata};
    sum_sat  = sum_wide[COUNT_BITS] ? '1 : sum_wide[COUNT_BITS-1:0];
    inc      = (mem_rdata == '1) ? mem_rdata : mem_rdata + count_t'(1);

    rank_wide = CMP_BITS'(sum) + CMP_BITS'(1);
    rank_sat  = (rank_wide > CMP_BITS'({RANK_BITS{1'b1}})) ? '1 : rank_wide[RANK_BITS-1:0];

    mem_we    = ctrl.clear | (ctrl.insert & pend);
    mem_waddr = ctrl.clear ? ctrl.clr_addr : wr_addr;
    mem_wdata = ctrl.clear ? '0 : inc;

    stat.done = !in_range(pos) && !pend;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend       <= 1'b0;
      rank_valid <= 1'b0;
    end else begin
      pend       <= mem_re;
      rank_valid <= ctrl.prefix & stat.done;
    end
  end

  always_ff @(posedge clk) begin
    wr_addr <= mem_raddr;
    if (ctrl.load) begin
      pos       <= key_pos;
      start_pos <= key_pos;
      sum       <= '0;
    end else if (ctrl.prefix && stat.done) begin
      pos  <= start_pos;
      rank <= rank_sat;
    end else begin
      if (mem_re) pos <= pos_step;
      if (ctrl.prefix && pend) sum <= sum_sat;
    end
  end

endmodule

### design/frc_checker.sv
`include "fenwick_rank_counter_core_defines.svh"

module frc_checker
  import frc_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 start,
  input logic                 busy,
  input logic                 func,
  input logic [KEY_BITS-1:0]  key,
  input logic [RANK_BITS-1:0] rank,
  input logic                 rank_valid
);

  // a rank beat only shows up mid-item
  `FRC_ASSERT_NOW(a_rank_in_item, rank_valid, busy, "rank beat while idle")
  // rank is never zero
  `FRC_ASSERT_NOW(a_rank_nonzero, rank_valid, rank != '0, "rank beat with zero rank")
  // one beat per item
  `FRC_ASSERT_NEXT(a_rank_single, rank_valid, !rank_valid, "rank strobe held two cycles")
  // an accepted beat makes the block busy
  `FRC_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "not busy after accept")
  // an insert-only item never reports
  `FRC_ASSERT_NEXT(a_insert_quiet, start && !busy && !func, !rank_valid,
                   "rank beat after insert-only accept")

endmodule

bind fenwick_rank_counter_core frc_checker u_frc_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .func       (func),
  .key        (key),
  .rank       (rank),
  .rank_valid (rank_valid)
);
